>>> rtl/sha_pkg.sv
// sha-256 stream hasher package: round constants, initial hash, command/status types
// no dependencies
`timescale 1ns / 1ps
package sha_pkg;

    localparam int WordW = 32;

    // controller to datapath commands
    typedef struct packed {
        logic load_byte;   // write one byte into the block buffer
        logic pad_byte;    // write the 0x80 marker at the current position, zero the bytes above it
        logic clear_tail;  // zero the buffer from position+1 upward (write mask)
        logic clear_all;   // zero the whole buffer
        logic put_length;  // put bit count into words 14 and 15
        logic start_comp;  // load working vars, start 64 rounds
        logic reset_hash;  // back to initial values
        logic shift_out;   // rotate hash words for output
    } sha_cmd_t;

    typedef struct packed {
        logic       comp_busy;
        logic       block_full;  // byte position wrapped to zero after load
        logic [5:0] byte_pos;
    } sha_stat_t;

    function automatic logic [31:0] sha_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [255:0] sha_init();
        return {32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    endfunction

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

endpackage

>>> rtl/sha256_stream_hasher.sv
// sha-256 stream hasher top level: controller plus datapath
// depends on sha_pkg, sha_ctrl, sha_datapath
`timescale 1ns / 1ps
// Usage:
//   s_axis: one word per message byte. tdata[7:0] is the byte, tuser[0] says
//   the byte is part of the message, tlast ends the message (may come with
//   no byte, so an empty message works).
//   m_axis: eight digest words, word 0 first, tuser carries the index and
//   tlast marks word 7.
// Throughput: a byte that does not fill a block passes through S_CHK before
//   the next byte is taken. The 64th byte of a block starts the shared round
//   unit, one round per cycle, and no byte is taken until that compression
//   ends; the round unit sets the rate.
// Finish: padding plus one or two compressions before the first digest
//   word, then eight words out.
// Reset: synchronous active low aresetn restores the initial hash, clears
//   the bit count and byte position.
// Stall: while m_tready is low the current word holds; no input is taken
//   until the whole digest has left.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import sha_pkg::*;

    sha_cmd_t  cmd;
    sha_stat_t stat;

    sha_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .byte_valid(s_tuser),
        .end_msg   (s_tlast),
        .stat      (stat),
        .cmd       (cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (m_tuser)
    );

    sha_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .byte_in (s_tdata),
        .stat    (stat),
        .out_word(m_tdata)
    );

    assign m_tlast = (m_tuser == 3'd7);
endmodule

>>> rtl/sha_datapath.sv
// sha-256 datapath: block buffer, bit count, message schedule, round unit, hash words
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  sha_pkg::sha_cmd_t cmd,
    input  logic [7:0]       byte_in,
    output sha_pkg::sha_stat_t stat,
    output logic [31:0]      out_word
);
    import sha_pkg::*;

    logic [31:0] buf_reg [16];
    logic [31:0] buf_next [16];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [63:0] cnt_reg, cnt_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        busy_reg, busy_next;
    logic        full_reg, full_next;

    logic [31:0] s0, s1, wnew, t1, t2, e, a, bs1, bs0, ch, maj;
    logic [255:0] iv;

    always_comb begin
        iv = sha_init();
        // schedule expansion from sliding window
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
           ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
           ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        // one compression round
        e   = v_reg[4];
        a   = v_reg[0];
        bs1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch  = (e & v_reg[5]) ^ (~e & v_reg[6]);
        t1  = v_reg[7] + bs1 + ch + sha_k(rnd_reg) + w_reg[0];
        bs0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        maj = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = bs0 + maj;

        buf_next  = buf_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        v_next    = v_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        full_next = 1'b0;

        // buffer writes
        if (cmd.load_byte) begin
            buf_next[pos_reg[5:2]][(5'd24 - {pos_reg[1:0], 3'b000}) +: 8] = byte_in;
            cnt_next = cnt_reg + 64'd8;
            pos_next = pos_reg + 6'd1;
            full_next = (pos_reg == 6'd63);
        end
        if (cmd.pad_byte) begin
            for (int p = 0; p < 64; p++) begin
                if (6'(p) == pos_reg)
                    buf_next[p/4][(24 - 8*(p%4)) +: 8] = PadByte;
                else if (6'(p) > pos_reg)
                    buf_next[p/4][(24 - 8*(p%4)) +: 8] = 8'h00;
            end
        end
        if (cmd.clear_tail) begin
            for (int p = 0; p < 64; p++)
                if (6'(p) > pos_reg)
                    buf_next[p/4][(24 - 8*(p%4)) +: 8] = 8'h00;
        end
        if (cmd.clear_all)
            for (int i = 0; i < 16; i++) buf_next[i] = '0;
        if (cmd.put_length) begin
            buf_next[14] = cnt_reg[63:32];
            buf_next[15] = cnt_reg[31:0];
        end

        // compression sequencing
        if (cmd.start_comp) begin
            w_next = buf_reg;
            v_next = h_reg;
            rnd_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int i = 0; i < 15; i++) w_next[i] = w_reg[i+1];
            w_next[15] = wnew;
            v_next[7] = v_reg[6]; v_next[6] = v_reg[5]; v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2]; v_next[2] = v_reg[1]; v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            rnd_next = rnd_reg + 6'd1;
            if (rnd_reg == 6'd63) begin
                busy_next = 1'b0;
                h_next[0] = h_reg[0] + t1 + t2;
                h_next[1] = h_reg[1] + v_reg[0];
                h_next[2] = h_reg[2] + v_reg[1];
                h_next[3] = h_reg[3] + v_reg[2];
                h_next[4] = h_reg[4] + v_reg[3] + t1;
                h_next[5] = h_reg[5] + v_reg[4];
                h_next[6] = h_reg[6] + v_reg[5];
                h_next[7] = h_reg[7] + v_reg[6];
            end
        end

        // digest readout rotates words toward index 0
        if (cmd.shift_out) begin
            for (int i = 0; i < 7; i++) h_next[i] = h_reg[i+1];
            h_next[7] = h_reg[0];
        end
        if (cmd.reset_hash) begin
            for (int i = 0; i < 8; i++) h_next[i] = iv[(7-i)*32 +: 32];
            cnt_next = '0;
            pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        w_reg   <= w_next;
        v_reg   <= v_next;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= iv[(7-i)*32 +: 32];
            cnt_reg  <= '0;
            pos_reg  <= '0;
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            full_reg <= 1'b0;
        end else begin
            h_reg    <= h_next;
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
            rnd_reg  <= rnd_next;
            busy_reg <= busy_next;
            full_reg <= full_next;
        end
    end

    assign stat.comp_busy  = busy_reg;
    assign stat.block_full = full_reg;
    assign stat.byte_pos   = pos_reg;
    assign out_word        = h_reg[0];

    // rounds only run while busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |=> (rnd_reg == $past(rnd_reg)) || busy_reg)
        else $error("round counter moved while idle");
    // a byte is never loaded, and compression never restarted, during compression
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !cmd.load_byte && !cmd.start_comp)
        else $error("buffer touched during compression");
    // bit count moves by 8 on a byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_byte && !cmd.reset_hash |=> cnt_reg == $past(cnt_reg) + 64'd8)
        else $error("bit count step wrong");
endmodule

>>> rtl/sha_ctrl.sv
// sha-256 controller: input acceptance, padding sequence, digest readout
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               byte_valid,
    input  logic               end_msg,
    input  sha_pkg::sha_stat_t stat,
    output sha_pkg::sha_cmd_t  cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         out_index
);
    import sha_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHK   = 8'b0000_0010,
        S_WAITB = 8'b0000_0100,
        S_PAD   = 8'b0000_1000,
        S_COMP1 = 8'b0001_0000,
        S_LEN   = 8'b0010_0000,
        S_COMP2 = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;
    logic   two_reg, two_next;
    logic [2:0] idx_reg, idx_next;
    logic   acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign acc       = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        two_next   = two_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    cmd.load_byte = byte_valid;
                    fin_next      = end_msg;
                    if (byte_valid || end_msg) state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (stat.block_full) begin
                    cmd.start_comp = 1'b1;
                    state_next     = S_WAITB;
                end else if (fin_reg) begin
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_WAITB: begin
                if (!stat.comp_busy)
                    state_next = fin_reg ? S_PAD : S_IDLE;
            end
            S_PAD: begin
                cmd.pad_byte = 1'b1;
                two_next     = (stat.byte_pos >= LenPos);
                state_next   = S_COMP1;
            end
            S_COMP1: begin
                if (two_reg) begin
                    cmd.start_comp = 1'b1;
                    two_next       = 1'b0;
                end else if (!stat.comp_busy) begin
                    state_next = S_LEN;
                end
            end
            S_LEN: begin
                if (stat.byte_pos >= LenPos && !two_reg && fin_reg) begin
                    cmd.clear_all = 1'b1;
                end
                cmd.put_length = 1'b1;
                state_next     = S_COMP2;
                fin_next       = 1'b0;
            end
            S_COMP2: begin
                if (!fin_reg) begin
                    cmd.start_comp = 1'b1;
                    fin_next       = 1'b1;
                end else if (!stat.comp_busy) begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_ready) begin
                    cmd.shift_out = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.reset_hash = 1'b1;
                        fin_next       = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            two_reg   <= two_next;
            idx_reg   <= idx_next;
        end
    end

    // input is only taken when no digest is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> !in_ready)
        else $error("input open during readout");
    // last word returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_ready && idx_reg == 3'd7 |=> state_reg == S_IDLE)
        else $error("readout did not finish");
    // compression never restarted while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.comp_busy |-> !cmd.start_comp)
        else $error("compression restarted");
endmodule
